/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that cons holds in the same cycle as ante
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that cons holds in the cycle after ante
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mtcu_pkg.sv */
package mtcu_pkg;

    localparam int ITEM_W = 136;
    localparam int RES_W  = 224;

    localparam int ALIGN_BYTES = 4;
    localparam logic [31:0] ALIGN_MASK = 32'(ALIGN_BYTES - 1);

    localparam logic [31:0] MPP_BITS      = 32'h0000_1800;
    localparam logic [31:0] ILLEGAL_CAUSE = 32'd2;

    localparam logic [31:0] CAUSE_IRQ      = 32'h8000_0000;
    localparam logic [3:0]  IRQ_CODE_SW    = 4'd3;
    localparam logic [3:0]  IRQ_CODE_TIMER = 4'd7;
    localparam logic [3:0]  IRQ_CODE_EXT   = 4'd11;

    typedef enum logic [3:0] {
        ACT_LINES     = 4'd0,
        ACT_TICK      = 4'd1,
        ACT_COMMIT    = 4'd2,
        ACT_EXCEPTION = 4'd3,
        ACT_POLL      = 4'd4,
        ACT_MRET      = 4'd5,
        ACT_CSR       = 4'd6,
        ACT_WFI       = 4'd7,
        ACT_START     = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_TRAP      = 3'd1,
        ST_NONE      = 3'd2,
        ST_SLEEP     = 3'd3,
        ST_BAD_ENTRY = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_REPLACE = 2'd0,
        OP_SET     = 2'd1,
        OP_CLEAR   = 2'd2
    } t_csr_op;

    localparam logic [11:0] CSR_MSTATUS   = 12'h300;
    localparam logic [11:0] CSR_MISA      = 12'h301;
    localparam logic [11:0] CSR_MIE       = 12'h304;
    localparam logic [11:0] CSR_MTVEC     = 12'h305;
    localparam logic [11:0] CSR_MSTATUSH  = 12'h310;
    localparam logic [11:0] CSR_MCNTINH   = 12'h320;
    localparam logic [11:0] CSR_HPMEVT_LO = 12'h323;
    localparam logic [11:0] CSR_HPMEVT_HI = 12'h33F;
    localparam logic [11:0] CSR_MSCRATCH  = 12'h340;
    localparam logic [11:0] CSR_MEPC      = 12'h341;
    localparam logic [11:0] CSR_MCAUSE    = 12'h342;
    localparam logic [11:0] CSR_MTVAL     = 12'h343;
    localparam logic [11:0] CSR_MIP       = 12'h344;
    localparam logic [11:0] CSR_MCYCLE    = 12'hB00;
    localparam logic [11:0] CSR_MINSTRET  = 12'hB02;
    localparam logic [11:0] CSR_HPMCL_LO  = 12'hB03;
    localparam logic [11:0] CSR_HPMCL_HI  = 12'hB1F;
    localparam logic [11:0] CSR_MCYCLEH   = 12'hB80;
    localparam logic [11:0] CSR_MINSTRETH = 12'hB82;
    localparam logic [11:0] CSR_HPMCH_LO  = 12'hB83;
    localparam logic [11:0] CSR_HPMCH_HI  = 12'hB9F;
    localparam logic [11:0] CSR_ID_LO     = 12'hF11;
    localparam logic [11:0] CSR_ID_HI     = 12'hF15;

    // architectural state; ie: bit0 MIE, bit1 MPIE; irq bits: sw, timer, ext
    typedef struct packed {
        logic [31:0] pc;
        logic [1:0]  ie;
        logic [2:0]  irq_en;
        logic [2:0]  irq_pend;
        logic [31:0] mtvec;
        logic [31:0] mepc;
        logic [31:0] mcause;
        logic [31:0] mtval;
        logic [31:0] mscratch;
        logic [1:0]  inhibit;
        logic [63:0] cycle;
        logic [63:0] instret;
        logic [63:0] retired;
        logic        wfi_wait;
    } t_state;

    typedef struct packed {
        logic        known;
        logic [31:0] data;
    } t_csr_rd;

    typedef struct packed {
        logic        count_retire;
        logic [2:0]  irq_lines;
        logic [15:0] elapsed;
        logic        csr_write;
        logic [31:0] csr_source;
        logic [1:0]  csr_op;
        logic [11:0] csr_addr;
        logic [31:0] trap_value;
        logic [4:0]  exc_cause;
        logic [31:0] next_pc;
    } t_item;

    typedef struct packed {
        logic [63:0] retired_count;
        logic [31:0] csr_read_data;
        logic [31:0] trap_value_out;
        logic [31:0] trap_cause_out;
        logic [31:0] new_pc;
        logic [31:0] old_pc;
    } t_result;

    function automatic logic [31:0] irq_to_csr(input logic [2:0] b);
        logic [31:0] v;
        v = '0;
        v[3]  = b[0];
        v[7]  = b[1];
        v[11] = b[2];
        return v;
    endfunction

endpackage

/* design/machine_trap_csr_unit.sv */
// A transaction passes through the input register, then the result register, to its result.
// Throughput: one transaction per cycle unless m_axis_tready stalls; state updates in the same
// cycle as the result register loads, so each transaction sees the state left by the one before it.
// Reset (i_rst_n low, synchronous): all architectural state and both valid flags clear;
// no clearing pass, transactions are taken in the first cycle after reset.
`include "assert_macros.svh"

module machine_trap_csr_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // next_pc, exc_cause, trap_value, csr_addr, csr_op, csr_source, csr_write,
    // elapsed, irq_lines, count_retire
    input  logic [mtcu_pkg::ITEM_W-1:0]   s_axis_tdata,
    // action
    input  logic [3:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // old_pc, new_pc, trap_cause_out, trap_value_out, csr_read_data, retired_count
    output logic [mtcu_pkg::RES_W-1:0]    m_axis_tdata,
    // status
    output logic [2:0]                    m_axis_tuser
);
    import mtcu_pkg::*;

    logic        r_in_valid;
    t_item       r_in_item;
    logic [3:0]  r_in_action;
    logic        r_out_valid;
    t_result     r_out_data;
    t_status     r_out_status;
    t_state      r_state;

    t_state      n_state;
    t_result     n_result;
    t_status     n_status;
    t_csr_rd     w_rd;
    logic        w_proc;
    logic        w_commit;
    logic [31:0] w_commit_pc;
    logic        w_commit_cnt;
    logic        w_trap;
    logic [31:0] w_trap_cause;
    logic [31:0] w_trap_val;
    logic        w_store;
    logic [31:0] w_csr_val;
    logic [2:0]  w_irq;

    assign w_proc        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_proc;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;

    mtcu_csr_read u_csr_read (
        .i_state (r_state),
        .i_addr  (r_in_item.csr_addr),
        .o_rd    (w_rd)
    );

    always_comb begin
        n_state      = r_state;
        n_status     = ST_NONE;
        n_result     = '0;
        w_commit     = 1'b0;
        w_commit_pc  = r_in_item.next_pc;
        w_commit_cnt = 1'b1;
        w_trap       = 1'b0;
        w_trap_cause = '0;
        w_trap_val   = '0;
        w_store      = 1'b0;
        w_irq        = r_state.irq_pend & r_state.irq_en;

        case (r_in_item.csr_op)
            OP_REPLACE: w_csr_val = r_in_item.csr_source;
            OP_SET:     w_csr_val = w_rd.data | r_in_item.csr_source;
            default:    w_csr_val = w_rd.data & ~r_in_item.csr_source;
        endcase

        case (r_in_action)
            ACT_LINES: n_state.irq_pend = r_in_item.irq_lines;
            ACT_TICK: begin
                if (!r_state.inhibit[0]) begin
                    n_state.cycle = r_state.cycle + 64'(r_in_item.elapsed);
                end
            end
            ACT_COMMIT: begin
                w_commit     = 1'b1;
                w_commit_cnt = r_in_item.count_retire;
                n_status     = ST_DONE;
            end
            ACT_EXCEPTION: begin
                w_trap       = 1'b1;
                w_trap_cause = 32'(r_in_item.exc_cause);
                w_trap_val   = r_in_item.trap_value;
            end
            ACT_POLL: begin
                if (w_irq != 3'b000) begin
                    n_state.wfi_wait = 1'b0;
                end
                if (w_irq != 3'b000 && r_state.ie[0]) begin
                    w_trap          = 1'b1;
                    w_trap_cause    = CAUSE_IRQ;
                    w_trap_cause[3:0] = w_irq[2] ? IRQ_CODE_EXT :
                                        (w_irq[0] ? IRQ_CODE_SW : IRQ_CODE_TIMER);
                end else begin
                    n_status = (w_irq == 3'b000 && r_state.wfi_wait) ? ST_SLEEP : ST_NONE;
                end
            end
            ACT_MRET: begin
                n_state.ie  = {1'b1, r_state.ie[1]};
                w_commit    = 1'b1;
                w_commit_pc = r_state.mepc;
                n_status    = ST_DONE;
            end
            ACT_CSR: begin
                if (!w_rd.known || (r_in_item.csr_write && r_in_item.csr_addr[11:10] == 2'b11))
                begin
                    w_trap       = 1'b1;
                    w_trap_cause = ILLEGAL_CAUSE;
                    w_trap_val   = r_in_item.trap_value;
                end else begin
                    w_commit     = 1'b1;
                    w_commit_cnt = !(r_in_item.csr_write &&
                                     (r_in_item.csr_addr == CSR_MINSTRET ||
                                      r_in_item.csr_addr == CSR_MINSTRETH));
                    w_store      = r_in_item.csr_write;
                    n_result.csr_read_data = w_rd.data;
                    n_status     = ST_DONE;
                end
            end
            ACT_WFI: begin
                n_state.wfi_wait = 1'b1;
                w_commit         = 1'b1;
                n_status         = ST_DONE;
            end
            ACT_START: begin
                if ((r_in_item.next_pc & ALIGN_MASK) != 32'd0) begin
                    n_status = ST_BAD_ENTRY;
                end else begin
                    n_state.pc       = r_in_item.next_pc;
                    n_state.wfi_wait = 1'b0;
                    n_status         = ST_DONE;
                end
            end
            default: n_status = ST_NONE;
        endcase

        if (w_commit) begin
            n_state.pc      = w_commit_pc;
            n_state.retired = r_state.retired + 64'd1;
            if (w_commit_cnt && !r_state.inhibit[1]) begin
                n_state.instret = r_state.instret + 64'd1;
            end
        end

        if (w_store) begin
            case (r_in_item.csr_addr)
                CSR_MSTATUS:   n_state.ie = {w_csr_val[7], w_csr_val[3]};
                CSR_MIE:       n_state.irq_en = {w_csr_val[11], w_csr_val[7], w_csr_val[3]};
                CSR_MTVEC:     n_state.mtvec = {w_csr_val[31:2], 1'b0,
                                                w_csr_val[1:0] == 2'b01};
                CSR_MCNTINH:   n_state.inhibit = {w_csr_val[2], w_csr_val[0]};
                CSR_MSCRATCH:  n_state.mscratch = w_csr_val;
                CSR_MEPC:      n_state.mepc = w_csr_val & ~ALIGN_MASK;
                CSR_MCAUSE:    n_state.mcause = w_csr_val;
                CSR_MTVAL:     n_state.mtval = w_csr_val;
                CSR_MCYCLE:    n_state.cycle[31:0] = w_csr_val;
                CSR_MCYCLEH:   n_state.cycle[63:32] = w_csr_val;
                CSR_MINSTRET:  n_state.instret[31:0] = w_csr_val;
                CSR_MINSTRETH: n_state.instret[63:32] = w_csr_val;
                default:       n_state.mscratch = r_state.mscratch;
            endcase
        end

        if (w_trap) begin
            n_state.mepc     = r_state.pc;
            n_state.mcause   = w_trap_cause;
            n_state.mtval    = w_trap_val;
            n_state.ie       = {r_state.ie[0], 1'b0};
            n_state.wfi_wait = 1'b0;
            n_state.pc       = {r_state.mtvec[31:2], 2'b00} +
                               ((w_trap_cause[31] && r_state.mtvec[1:0] == 2'b01) ?
                                {w_trap_cause[29:0], 2'b00} : 32'd0);
            n_result.trap_cause_out = w_trap_cause;
            n_result.trap_value_out = w_trap_val;
            n_status         = ST_TRAP;
        end

        n_result.old_pc        = r_state.pc;
        n_result.new_pc        = n_state.pc;
        n_result.retired_count = n_state.retired;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item   <= t_item'(s_axis_tdata);
            r_in_action <= s_axis_tuser;
        end
        if (w_proc) begin
            r_out_data   <= n_result;
            r_out_status <= n_status;
        end
    end

    `CHK_IMPLY(a_mtvec_mode, 1'b1, r_state.mtvec[1] == 1'b0, "mtvec holds a reserved mode")
    `CHK_NEXT(a_trap_wakes, w_proc && n_status == ST_TRAP, !r_state.wfi_wait, "trap left wait set")
    `CHK_NEXT(a_commit_count, w_proc && w_commit, r_state.retired == $past(r_state.retired) + 64'd1, "retire total not advanced")

endmodule

/* design/mtcu_csr_read.sv */
module mtcu_csr_read (
    input  mtcu_pkg::t_state  i_state,
    input  logic [11:0]       i_addr,
    output mtcu_pkg::t_csr_rd o_rd
);
    import mtcu_pkg::*;

    always_comb begin
        o_rd.known = 1'b1;
        o_rd.data  = '0;
        case (i_addr)
            CSR_MSTATUS: begin
                o_rd.data    = MPP_BITS;
                o_rd.data[3] = i_state.ie[0];
                o_rd.data[7] = i_state.ie[1];
            end
            CSR_MIE:       o_rd.data = irq_to_csr(i_state.irq_en);
            CSR_MTVEC:     o_rd.data = i_state.mtvec;
            CSR_MCNTINH: begin
                o_rd.data[0] = i_state.inhibit[0];
                o_rd.data[2] = i_state.inhibit[1];
            end
            CSR_MSCRATCH:  o_rd.data = i_state.mscratch;
            CSR_MEPC:      o_rd.data = i_state.mepc;
            CSR_MCAUSE:    o_rd.data = i_state.mcause;
            CSR_MTVAL:     o_rd.data = i_state.mtval;
            CSR_MIP:       o_rd.data = irq_to_csr(i_state.irq_pend);
            CSR_MCYCLE:    o_rd.data = i_state.cycle[31:0];
            CSR_MCYCLEH:   o_rd.data = i_state.cycle[63:32];
            CSR_MINSTRET:  o_rd.data = i_state.instret[31:0];
            CSR_MINSTRETH: o_rd.data = i_state.instret[63:32];
            default: begin
                o_rd.known = i_addr inside {CSR_MISA, CSR_MSTATUSH,
                                            [CSR_HPMEVT_LO:CSR_HPMEVT_HI],
                                            [CSR_HPMCL_LO:CSR_HPMCL_HI],
                                            [CSR_HPMCH_LO:CSR_HPMCH_HI],
                                            [CSR_ID_LO:CSR_ID_HI]};
            end
        endcase
    end

endmodule
